### hdl/bit_slice_alu_16bit_defines.svh
// assertion helpers for the bit-slice alu
`ifndef BIT_SLICE_ALU_16BIT_DEFINES_SVH
`define BIT_SLICE_ALU_16BIT_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define BSA_ASSERT_HOLD(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent now implies consequent at the next edge
`define BSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// antecedent implies consequent at the same edge
`define BSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BSA_ASSERT_HOLD(lbl, clk, rst, cond, msg)
`define BSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define BSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hdl/bsa_pkg.sv
package bsa_pkg;

   localparam int DATA_WIDTH = 16;
   // register count, a power of two so the address wraps by truncation
   localparam int NUM_REGS   = 16;
   localparam int REG_AW     = $clog2(NUM_REGS);

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [REG_AW-1:0]     raddr_type;

   // operand pair (R,S)
   typedef enum logic [2:0] {
      SRC_AQ = 3'd0,
      SRC_AB = 3'd1,
      SRC_ZQ = 3'd2,
      SRC_ZB = 3'd3,
      SRC_ZA = 3'd4,
      SRC_DA = 3'd5,
      SRC_DQ = 3'd6,
      SRC_DZ = 3'd7
   } src_type;

   typedef enum logic [2:0] {
      FN_ADD   = 3'd0,   // r + s + c
      FN_SUBR  = 3'd1,   // s - r - c
      FN_SUBS  = 3'd2,   // r - s - c
      FN_OR    = 3'd3,
      FN_AND   = 3'd4,
      FN_NOTRS = 3'd5,   // ~r & s
      FN_EXOR  = 3'd6,
      FN_EXNOR = 3'd7
   } fn_type;

   typedef enum logic [2:0] {
      DST_QREG  = 3'd0,  // f to q
      DST_NOP   = 3'd1,
      DST_RAMA  = 3'd2,  // f to b, y shows a
      DST_RAMF  = 3'd3,  // f to b
      DST_RAMQD = 3'd4,  // f and q shifted down
      DST_RAMD  = 3'd5,  // f shifted down
      DST_RAMQU = 3'd6,  // f and q shifted up
      DST_RAMU  = 3'd7   // f shifted up
   } dst_type;

   // request item layout, last member in the lowest bits
   typedef struct packed {
      logic [1:0] pad;
      logic       q_lsb_in;
      logic       q_msb_in;
      logic       ram_lsb_in;
      logic       ram_msb_in;
      logic       carry_in;
      logic [3:0] addr_b;
      logic [3:0] addr_a;
      word_type   data_in;
      logic [8:0] func;
   } req_data_type;

   // response item layout, last member in the lowest bits
   typedef struct packed {
      logic     q_msb_out;
      logic     q_lsb_out;
      logic     ram_msb_out;
      logic     ram_lsb_out;
      logic     overflow_flag;
      logic     sign_flag;
      logic     zero_flag;
      logic     carry_out;
      word_type y_out;
   } rsp_data_type;

   typedef struct packed {
      logic      en;
      raddr_type addr;
      word_type  data;
   } rf_wr_type;

   typedef struct packed {
      logic     en;
      word_type data;
   } q_wr_type;

endpackage

### hdl/bsa_regfile.sv
module bsa_regfile (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_load,
   input  bsa_pkg::raddr_type  rd_addr_a,
   input  bsa_pkg::raddr_type  rd_addr_b,
   input  bsa_pkg::rf_wr_type  wr,
   output bsa_pkg::word_type   ra,
   output bsa_pkg::word_type   rb
);

   bsa_pkg::word_type             mem_ff [bsa_pkg::NUM_REGS];
   logic [bsa_pkg::NUM_REGS-1:0]  vld_ff;
   bsa_pkg::word_type             ra_ff;
   bsa_pkg::word_type             rb_ff;

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // operand read with bypass of the write landing on the same edge
   always_ff @(posedge clock) begin
      if (rd_load) begin
         priority if (wr.en && (wr.addr == rd_addr_a)) begin
            ra_ff <= wr.data;
         end else if (vld_ff[rd_addr_a]) begin
            ra_ff <= mem_ff[rd_addr_a];
         end else begin
            ra_ff <= '0;
         end
         priority if (wr.en && (wr.addr == rd_addr_b)) begin
            rb_ff <= wr.data;
         end else if (vld_ff[rd_addr_b]) begin
            rb_ff <= mem_ff[rd_addr_b];
         end else begin
            rb_ff <= '0;
         end
      end
   end

   assign ra = ra_ff;
   assign rb = rb_ff;

endmodule

### hdl/bsa_alu.sv
module bsa_alu (
   input  bsa_pkg::req_data_type instr,
   input  bsa_pkg::word_type     ra,
   input  bsa_pkg::word_type     rb,
   input  bsa_pkg::word_type     q,
   output bsa_pkg::rsp_data_type rsp,
   output bsa_pkg::rf_wr_type    rf_wr,
   output bsa_pkg::q_wr_type     q_wr
);

   localparam int W = bsa_pkg::DATA_WIDTH;

   bsa_pkg::src_type  src;
   bsa_pkg::fn_type   fn;
   bsa_pkg::dst_type  dst;
   bsa_pkg::word_type r;
   bsa_pkg::word_type s;
   bsa_pkg::word_type x;
   bsa_pkg::word_type y;
   bsa_pkg::word_type f;
   logic [W:0]        sum;
   logic [W:0]        diff;
   logic [W:0]        cin;
   logic              cy;
   logic              ov;

   assign src = bsa_pkg::src_type'(instr.func[2:0]);
   assign fn  = bsa_pkg::fn_type'(instr.func[5:3]);
   assign dst = bsa_pkg::dst_type'(instr.func[8:6]);
   assign cin = {{W{1'b0}}, instr.carry_in};

   always_comb begin
      unique case (src)
         bsa_pkg::SRC_AQ: begin r = ra;            s = q;  end
         bsa_pkg::SRC_AB: begin r = ra;            s = rb; end
         bsa_pkg::SRC_ZQ: begin r = '0;            s = q;  end
         bsa_pkg::SRC_ZB: begin r = '0;            s = rb; end
         bsa_pkg::SRC_ZA: begin r = '0;            s = ra; end
         bsa_pkg::SRC_DA: begin r = instr.data_in; s = ra; end
         bsa_pkg::SRC_DQ: begin r = instr.data_in; s = q;  end
         bsa_pkg::SRC_DZ: begin r = instr.data_in; s = '0; end
      endcase
   end

   // minuend x, subtrahend y
   assign x = (fn == bsa_pkg::FN_SUBR) ? s : r;
   assign y = (fn == bsa_pkg::FN_SUBR) ? r : s;

   assign sum  = {1'b0, r} + {1'b0, s} + cin;
   // top bit is the borrow
   assign diff = {1'b0, x} - {1'b0, y} - cin;

   always_comb begin
      cy = 1'b0;
      ov = 1'b0;
      unique case (fn)
         bsa_pkg::FN_ADD: begin
            f  = sum[W-1:0];
            cy = sum[W];
            ov = (r[W-1] ^ f[W-1]) & (s[W-1] ^ f[W-1]);
         end
         bsa_pkg::FN_SUBR,
         bsa_pkg::FN_SUBS: begin
            f  = diff[W-1:0];
            cy = diff[W];
            ov = (x[W-1] ^ y[W-1]) & (x[W-1] ^ f[W-1]);
         end
         bsa_pkg::FN_OR:    f = r | s;
         bsa_pkg::FN_AND:   f = r & s;
         bsa_pkg::FN_NOTRS: f = ~r & s;
         bsa_pkg::FN_EXOR:  f = r ^ s;
         bsa_pkg::FN_EXNOR: f = ~(r ^ s);
      endcase
   end

   always_comb begin
      rf_wr.en   = 1'b0;
      rf_wr.addr = instr.addr_b[bsa_pkg::REG_AW-1:0];
      rf_wr.data = f;
      q_wr.en    = 1'b0;
      q_wr.data  = f;

      rsp.y_out         = (dst == bsa_pkg::DST_RAMA) ? ra : f;
      rsp.carry_out     = cy;
      rsp.zero_flag     = (f == '0);
      rsp.sign_flag     = f[W-1];
      rsp.overflow_flag = ov;
      rsp.ram_lsb_out   = 1'b0;
      rsp.ram_msb_out   = 1'b0;
      rsp.q_lsb_out     = 1'b0;
      rsp.q_msb_out     = 1'b0;

      unique case (dst)
         bsa_pkg::DST_QREG: q_wr.en = 1'b1;
         bsa_pkg::DST_NOP:  ;
         bsa_pkg::DST_RAMA,
         bsa_pkg::DST_RAMF: rf_wr.en = 1'b1;
         bsa_pkg::DST_RAMQD,
         bsa_pkg::DST_RAMD: begin
            rf_wr.en        = 1'b1;
            rf_wr.data      = {instr.ram_msb_in, f[W-1:1]};
            rsp.ram_lsb_out = f[0];
            if (dst == bsa_pkg::DST_RAMQD) begin
               q_wr.en       = 1'b1;
               q_wr.data     = {instr.q_msb_in, q[W-1:1]};
               rsp.q_lsb_out = q[0];
            end
         end
         bsa_pkg::DST_RAMQU,
         bsa_pkg::DST_RAMU: begin
            rf_wr.en        = 1'b1;
            rf_wr.data      = {f[W-2:0], instr.ram_lsb_in};
            rsp.ram_msb_out = f[W-1];
            if (dst == bsa_pkg::DST_RAMQU) begin
               q_wr.en       = 1'b1;
               q_wr.data     = {q[W-2:0], instr.q_lsb_in};
               rsp.q_msb_out = q[W-1];
            end
         end
      endcase
   end

endmodule

### hdl/bit_slice_alu_16bit.sv
// bit-slice alu with 16x16 register file and q register, one microinstruction per item
// an accepted item passes the input register, then the result register, where rsp_tvalid shows it
// throughput: 1 item per cycle while rsp_tready is high, set by the single alu pass between the two registers
// reset: synchronous active high; clears handshake state, q and register file valid bits
// register file entries read as zero until written, no clearing pass needed
`include "bit_slice_alu_16bit_defines.svh"

module bit_slice_alu_16bit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[8:0], data_in[24:9], addr_a[28:25], addr_b[32:29], carry_in[33],
   // ram_msb_in[34], ram_lsb_in[35], q_msb_in[36], q_lsb_in[37], zero[39:38]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // y_out[15:0], carry_out[16], zero_flag[17], sign_flag[18], overflow_flag[19],
   // ram_lsb_out[20], ram_msb_out[21], q_lsb_out[22], q_msb_out[23]
   output logic [23:0] rsp_tdata
);

   // input stage
   logic                  in_valid_ff;
   logic                  in_valid_in;
   bsa_pkg::req_data_type in_ff;
   bsa_pkg::req_data_type req_item;

   // result stage
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   bsa_pkg::rsp_data_type rsp_ff;
   bsa_pkg::rsp_data_type alu_rsp;

   // architectural q register
   bsa_pkg::word_type     q_ff;
   bsa_pkg::word_type     q_in;

   bsa_pkg::word_type     ra;
   bsa_pkg::word_type     rb;
   bsa_pkg::rf_wr_type    alu_rf_wr;
   bsa_pkg::rf_wr_type    rf_wr;
   bsa_pkg::q_wr_type     alu_q_wr;

   logic                  req_accept;
   logic                  advance;

   assign req_item = bsa_pkg::req_data_type'(req_tdata);

   // the item in the input stage moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= alu_rsp;
      end
   end

   // state writes commit as the item leaves, so the next item sees them
   assign q_in = (advance && alu_q_wr.en) ? alu_q_wr.data : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   always_comb begin
      rf_wr    = alu_rf_wr;
      rf_wr.en = alu_rf_wr.en && advance;
   end

   // operands are read as the item is accepted, with bypass of a same-edge write
   bsa_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_load   (req_accept),
      .rd_addr_a (req_item.addr_a[bsa_pkg::REG_AW-1:0]),
      .rd_addr_b (req_item.addr_b[bsa_pkg::REG_AW-1:0]),
      .wr        (rf_wr),
      .ra        (ra),
      .rb        (rb)
   );

   bsa_alu u_alu (
      .instr (in_ff),
      .ra    (ra),
      .rb    (rb),
      .q     (q_ff),
      .rsp   (alu_rsp),
      .rf_wr (alu_rf_wr),
      .q_wr  (alu_q_wr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // a new result only appears after an item sat in the input stage
   `BSA_ASSERT_SAME(a_rsp_from_input, clock, reset, $rose(rsp_valid_ff), $past(in_valid_ff), "result without item in input stage")
   // a stalled item stays in the input stage
   `BSA_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff, "input item dropped while stalled")
   // a register file write always comes with a result being loaded
   `BSA_ASSERT_NEXT(a_wr_has_rsp, clock, reset, rf_wr.en, rsp_valid_ff, "register write without result")
   // a shift goes one way only
   `BSA_ASSERT_HOLD(a_shift_dir, clock, reset, !(rsp_valid_ff && rsp_ff.ram_lsb_out && rsp_ff.ram_msb_out), "both shift outputs set")

endmodule
